>>> rtl/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg
// Shared types and constants of the work-stealing task dispatcher.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int NumQueues  = 8;
  localparam int QueueDepth = 16;
  localparam int TaskBits   = 16;

  localparam int QW = $clog2(NumQueues);
  localparam int DW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int NW = $clog2(NumQueues + 1);
  localparam int AW = QW + DW;

  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegCount = 2'd1;

  typedef enum logic [1:0] {
    OpAdd,
    OpTake,
    OpNone
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [QW-1:0]   queue;
    logic [AW-1:0]   addr;
    logic [TaskBits-1:0] task_id;
    logic [1:0]      status;
    logic            mem_wr;
    logic            mem_rd;
  } cmd_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StIssue
  } front_state_e;

endpackage

>>> rtl/wstd_ram.sv
// ----------------------------------------------------------------------------
// wstd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wstd_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wstd_front.sv
// ----------------------------------------------------------------------------
// wstd_front
// Accepts operations, picks the queue and updates the queue bookkeeping.
// ----------------------------------------------------------------------------
module wstd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          func_i,
  input  logic [wstd_pkg::TaskBits-1:0] task_id_i,
  input  logic [2:0]                    worker_i,
  input  logic                          mode_i,
  input  logic [wstd_pkg::NW-1:0]       count_i,
  input  logic                          slot_free_i,
  output logic                          busy_o,
  output logic                          cmd_valid_o,
  output wstd_pkg::cmd_t                cmd_o
);

  localparam int QW = wstd_pkg::QW;
  localparam int DW = wstd_pkg::DW;
  localparam int CW = wstd_pkg::CW;
  localparam int NQ = wstd_pkg::NumQueues;

  wstd_pkg::front_state_e state_q, state_d;

  logic [DW-1:0] top_q [NQ];
  logic [CW-1:0] cnt_q [NQ];
  logic [QW-1:0] victim_q [NQ];
  logic [QW-1:0] rr_q, rr_d;

  logic                          func_q, func_d;
  logic [wstd_pkg::TaskBits-1:0] task_q, task_d;
  logic [QW-1:0]                 worker_q, worker_d;
  logic [QW-1:0]                 idx_q, idx_d;
  logic [QW-1:0]                 best_q, best_d;
  logic                          found_q, found_d;
  logic [QW:0]                   step_q, step_d;
  logic                          inact_q, inact_d;

  logic [QW-1:0] nmax;
  logic [QW:0]   n;
  wstd_pkg::cmd_t cmd_d;
  logic           cmd_v_d;
  logic           upd_add, upd_own, upd_steal;
  logic [QW-1:0]  idx_inc;
  logic [QW-1:0]  vic_mod;

  always_comb begin
    if (count_i == '0) begin
      n = (QW+1)'(1);
    end else if (count_i > wstd_pkg::NW'(NQ)) begin
      n = (QW+1)'(NQ);
    end else begin
      n = (QW+1)'(count_i);
    end
    nmax = QW'(n - 1'b1);
    idx_inc = (idx_q == nmax) ? '0 : idx_q + 1'b1;
  end

  // last victim of the requester reduced mod n
  always_comb begin
    vic_mod = victim_q[QW'(worker_i)];
    for (int k = 0; k < QW; k++) begin
      if (vic_mod > nmax) vic_mod = vic_mod - n[QW-1:0];
    end
    if (n == (QW+1)'(1)) vic_mod = '0;
  end

  always_comb begin
    state_d  = state_q;
    rr_d     = rr_q;
    func_d   = func_q;
    task_d   = task_q;
    worker_d = worker_q;
    idx_d    = idx_q;
    best_d   = best_q;
    found_d  = found_q;
    step_d   = step_q;
    inact_d  = inact_q;
    cmd_v_d  = 1'b0;
    cmd_d    = '0;
    cmd_d.op = wstd_pkg::OpNone;
    upd_add  = 1'b0;
    upd_own  = 1'b0;
    upd_steal = 1'b0;
    unique case (state_q)
      wstd_pkg::StIdle: begin
        if (start_i) begin
          func_d   = func_i;
          task_d   = task_id_i;
          worker_d = QW'(worker_i);
          found_d  = 1'b0;
          step_d   = '0;
          inact_d  = ({1'b0, worker_i} >= 4'(n));
          if (!func_i) begin
            if (!mode_i) begin
              rr_d    = (rr_q >= nmax) ? '0 : rr_q + 1'b1;
              best_d  = rr_d;
              found_d = 1'b1;
              idx_d   = '0;
            end else begin
              best_d = '0;
              idx_d  = '0;
            end
          end else begin
            if (cnt_q[QW'(worker_i)] != '0 && {1'b0, worker_i} < 4'(n)) begin
              best_d  = QW'(worker_i);
              found_d = 1'b1;
            end
            // start from last victim mod n
            idx_d = vic_mod;
          end
          state_d = wstd_pkg::StScan;
        end
      end
      wstd_pkg::StScan: begin
        if (!func_q) begin
          if (mode_i && !found_q) begin
            if (cnt_q[idx_q] < cnt_q[best_q]) best_d = idx_q;
            if (idx_q == nmax) begin
              found_d = 1'b1;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            state_d = wstd_pkg::StIssue;
          end
        end else if (inact_q || found_q || step_q == n) begin
          state_d = wstd_pkg::StIssue;
        end else begin
          if (idx_q != worker_q && cnt_q[idx_q] != '0) begin
            best_d  = idx_q;
            found_d = 1'b1;
          end
          idx_d  = idx_inc;
          step_d = step_q + 1'b1;
        end
      end
      wstd_pkg::StIssue: begin
        if (slot_free_i) begin
          cmd_v_d = 1'b1;
          cmd_d.task_id = task_q;
          cmd_d.queue   = best_q;
          if (!func_q) begin
            cmd_d.op = wstd_pkg::OpAdd;
            cmd_d.addr = {best_q, DW'(top_q[best_q] + DW'(cnt_q[best_q]))};
            if (cnt_q[best_q] >= CW'(wstd_pkg::QueueDepth)) begin
              cmd_d.status = wstd_pkg::StatusFull;
            end else begin
              cmd_d.status = wstd_pkg::StatusDone;
              cmd_d.mem_wr = 1'b1;
              upd_add = 1'b1;
            end
          end else begin
            cmd_d.op = wstd_pkg::OpTake;
            if (inact_q || !found_q) begin
              cmd_d.status = wstd_pkg::StatusEmpty;
              cmd_d.queue  = '0;
            end else if (best_q == worker_q) begin
              cmd_d.status = wstd_pkg::StatusDone;
              cmd_d.mem_rd = 1'b1;
              cmd_d.addr = {best_q, DW'(top_q[best_q] + DW'(cnt_q[best_q] - 1'b1))};
              upd_own = 1'b1;
            end else begin
              cmd_d.status = wstd_pkg::StatusDone;
              cmd_d.mem_rd = 1'b1;
              cmd_d.addr = {best_q, top_q[best_q]};
              upd_steal = 1'b1;
            end
          end
          state_d = wstd_pkg::StIdle;
        end
      end
      default: state_d = wstd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wstd_pkg::StIdle;
      rr_q    <= '0;
      for (int i = 0; i < NQ; i++) begin
        top_q[i]    <= '0;
        cnt_q[i]    <= '0;
        victim_q[i] <= '0;
      end
      cmd_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rr_q    <= rr_d;
      cmd_valid_o <= cmd_v_d;
      if (upd_add) cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
      if (upd_own) cnt_q[best_q] <= cnt_q[best_q] - 1'b1;
      if (upd_steal) begin
        cnt_q[best_q]       <= cnt_q[best_q] - 1'b1;
        top_q[best_q]       <= top_q[best_q] + 1'b1;
        victim_q[worker_q]  <= best_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    task_q   <= task_d;
    worker_q <= worker_d;
    idx_q    <= idx_d;
    best_q   <= best_d;
    found_q  <= found_d;
    step_q   <= step_d;
    inact_q  <= inact_d;
    cmd_o    <= cmd_d;
  end

  assign busy_o = (state_q != wstd_pkg::StIdle);

`ifndef SYNTHESIS
  a_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_v_d |=> state_q == wstd_pkg::StIdle) else $error("issue not followed by idle");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wstd_pkg::StIssue && found_q) |->
    cnt_q[best_q] <= CW'(wstd_pkg::QueueDepth)) else $error("queue count overflow");
  a_one_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({upd_add, upd_own, upd_steal})) else $error("multiple updates");
`endif

endmodule

>>> rtl/wstd_back.sv
// ----------------------------------------------------------------------------
// wstd_back
// Carries out store accesses and presents the result beat.
// ----------------------------------------------------------------------------
module wstd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  wstd_pkg::cmd_t                cmd_i,
  output logic                          slot_free_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [wstd_pkg::TaskBits-1:0] task_out_o,
  output logic [2:0]                    queue_index_o
);

  logic [wstd_pkg::TaskBits-1:0] rdata;
  logic                          pend_q;
  logic                          rd_q;
  logic [1:0]                    status_q;
  logic [wstd_pkg::QW-1:0]       queue_q;

  wstd_ram #(
    .Width(wstd_pkg::TaskBits),
    .Depth(wstd_pkg::NumQueues * wstd_pkg::QueueDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_valid_i && cmd_i.mem_wr),
    .re_i   (cmd_valid_i && cmd_i.mem_rd),
    .addr_i (cmd_i.addr),
    .wdata_i(cmd_i.task_id),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      rd_q     <= cmd_i.mem_rd;
      status_q <= cmd_i.status;
      queue_q  <= cmd_i.queue;
    end
  end

  assign slot_free_o   = !pend_q;
  assign done_o        = pend_q;
  assign status_o      = status_q;
  assign task_out_o    = rd_q ? rdata : '0;
  assign queue_index_o = 3'(queue_q);

`ifndef SYNTHESIS
  a_no_back2back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !cmd_valid_i) else $error("command while result pending");
  a_zero_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != wstd_pkg::StatusDone) |-> task_out_o == '0)
    else $error("task on failed beat");
`endif

endmodule

>>> rtl/work_stealing_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_core
// Per-worker task deques with add placement and take/steal service.
// ----------------------------------------------------------------------------
// usage: pulse start while busy is low with func_i, task_id_i, worker_i.
// func_i low adds task_id_i to a queue picked round robin or as emptiest;
// func_i high gives worker_i its newest own task or steals the oldest task
// of another queue, searching from its last victim.
// each beat returns one result on done_o, valid for one cycle only; the
// receiver cannot stall, so the result is simply presented and dropped.
// flow: a beat moves from idle through the scan state to issue, where the
// command waits for a free store slot; least-occupied add and steal scan
// the queue counts. busy stays high until the command issues to the store,
// so a new beat may be taken before the last result is shown on done_o.
// config: cfg_we_i with cfg_idx_i 0 sets placement mode, 1 sets worker count;
// write only while idle.
// reset: all queues empty, round robin and victim pointers zero, mode round
// robin, eight workers. the task store is not cleared.
// ----------------------------------------------------------------------------
module work_stealing_task_dispatcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [wstd_pkg::TaskBits-1:0] task_id_i,
  input  logic [2:0]                    worker_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [3:0]                    cfg_data_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [wstd_pkg::TaskBits-1:0] task_out_o,
  output logic [2:0]                    queue_index_o
);

  logic                   mode_q;
  logic [3:0]             count_q;
  logic                   slot_free;
  logic                   cmd_valid;
  wstd_pkg::cmd_t         cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      count_q <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wstd_pkg::RegMode[0]) mode_q <= cfg_data_i[0];
      else count_q <= cfg_data_i;
    end
  end

  wstd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start && !busy),
    .func_i     (func_i),
    .task_id_i  (task_id_i),
    .worker_i   (worker_i),
    .mode_i     (mode_q),
    .count_i    (count_q),
    .slot_free_i(slot_free),
    .busy_o     (busy),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  wstd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .slot_free_o  (slot_free),
    .done_o       (done_o),
    .status_o     (status_o),
    .task_out_o   (task_out_o),
    .queue_index_o(queue_index_o)
  );

`ifndef SYNTHESIS
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status");
`endif

endmodule
